@@ rtl/lmbs_pkg.sv @@
// Shared types and constants of the bilinear light map sampler.
// Used by lmbs_axis, lmbs_blend and the top level; depends on nothing else.
package lmbs_pkg;

   // Fixed field widths of the item and register formats.
   localparam int POINT_WIDTH         = 24;
   localparam int ORIGIN_WIDTH        = 16;
   localparam int SIZE_WIDTH          = 13;
   localparam int ENTRY_INDEX_WIDTH   = 12;
   localparam int FIELD_CHANNEL_WIDTH = 16;

   // Row-major neighbor address: cell row times width plus column, with margin.
   localparam int NBR_ADDR_WIDTH = 27;

   // Stream and register port widths.
   localparam int REQ_TDATA_WIDTH = 112;
   localparam int RSP_TDATA_WIDTH = 48;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   // Item commands, carried in tuser.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAP_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_X   = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_Y   = 2'd3;

   // Register reset value and the smallest effective map size.
   localparam logic [SIZE_WIDTH-1:0] MAP_SIZE_RESET = 13'd64;
   localparam logic [SIZE_WIDTH-1:0] MAP_SIZE_MIN   = 13'd2;

   // Which of the four neighbors fall inside the map memory.
   typedef struct packed {
      logic a11;
      logic a01;
      logic a10;
      logic a00;
   } nbr_ok_type;

endpackage

@@ rtl/lmbs_axis.sv @@
// One axis of the sampling point: origin removal, cell/fraction split and clamp.
// Depends on lmbs_pkg.
module lmbs_axis #(
   parameter int FRAC_BITS = 8
) (
   input  logic signed [lmbs_pkg::POINT_WIDTH-1:0]  point,
   input  logic signed [lmbs_pkg::ORIGIN_WIDTH-1:0] origin,
   input  logic        [lmbs_pkg::SIZE_WIDTH-1:0]   size,
   output logic        [lmbs_pkg::SIZE_WIDTH-1:0]   cell_index,
   output logic        [FRAC_BITS:0]                frac
);

   localparam int RelWidth =
      ((lmbs_pkg::POINT_WIDTH > lmbs_pkg::ORIGIN_WIDTH + FRAC_BITS) ?
       lmbs_pkg::POINT_WIDTH : lmbs_pkg::ORIGIN_WIDTH + FRAC_BITS) + 1;
   localparam int CellWidth = RelWidth - FRAC_BITS;
   localparam logic [FRAC_BITS:0] FracOne = (FRAC_BITS + 1)'(1) << FRAC_BITS;

   logic signed [RelWidth-1:0]  point_ext;
   logic signed [RelWidth-1:0]  origin_ext;
   logic signed [RelWidth-1:0]  rel;
   logic signed [CellWidth-1:0] cell_raw;
   logic [lmbs_pkg::SIZE_WIDTH-1:0] size_eff;
   logic [lmbs_pkg::SIZE_WIDTH-1:0] size_m1;

   // Relative point in cell units; the arithmetic shift of the top bits is a floor.
   assign point_ext  = RelWidth'(point);
   assign origin_ext = RelWidth'(origin) <<< FRAC_BITS;
   assign rel        = point_ext - origin_ext;
   assign cell_raw   = rel[RelWidth-1:FRAC_BITS];

   // A map narrower than two cells behaves as two cells.
   assign size_eff = (size < lmbs_pkg::MAP_SIZE_MIN) ? lmbs_pkg::MAP_SIZE_MIN : size;
   assign size_m1  = size_eff - lmbs_pkg::SIZE_WIDTH'(1);

   // Keep the 2x2 neighborhood inside the map: before the map pins to the first
   // cell with no weight on the far side, at or past the last cell pins to the
   // second-last cell with full weight on the far side.
   always_comb begin
      if (cell_raw < 0) begin
         cell_index = '0;
         frac       = '0;
      end else if (cell_raw >= $signed(CellWidth'(size_m1))) begin
         cell_index = size_eff - lmbs_pkg::MAP_SIZE_MIN;
         frac       = FracOne;
      end else begin
         cell_index = lmbs_pkg::SIZE_WIDTH'(cell_raw);
         frac       = {1'b0, rel[FRAC_BITS-1:0]};
      end
   end

endmodule

@@ rtl/lmbs_light_mem.sv @@
// One copy of the light map: a synchronous memory with one write and two read ports.
// Depends on nothing; the read data is registered and held while rd_en is low.
module lmbs_light_mem #(
   parameter int DEPTH      = 4096,
   parameter int WORD_WIDTH = 48
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WORD_WIDTH-1:0]      wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr_b,
   output logic [WORD_WIDTH-1:0]      rd_data_a,
   output logic [WORD_WIDTH-1:0]      rd_data_b
);

   logic [WORD_WIDTH-1:0] store_mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // Two registered read ports.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= store_mem[rd_addr_a];
         rd_data_b <= store_mem[rd_addr_b];
      end
   end

endmodule

@@ rtl/lmbs_blend.sv @@
// Bilinear weighting of the four neighbor entries, halving and saturation.
// Two pipeline stages (products, then sum) with their own valid/ready; uses lmbs_pkg.
module lmbs_blend #(
   parameter int FRAC_BITS    = 8,
   parameter int CHANNEL_BITS = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         in_valid,
   output logic                                         in_ready,
   input  lmbs_pkg::nbr_ok_type                         in_ok,
   input  logic [3:0][2*FRAC_BITS:0]                    weight,
   input  logic [3:0][3*CHANNEL_BITS-1:0]               word,
   output logic                                         out_valid,
   input  logic                                         out_ready,
   output logic [2:0][lmbs_pkg::FIELD_CHANNEL_WIDTH-1:0] light
);

   localparam int WeightWidth = 2 * FRAC_BITS + 1;
   localparam int ProdWidth   = CHANNEL_BITS + WeightWidth;
   localparam int SumWidth    = ProdWidth + 2;
   localparam int ResWidth    = SumWidth - (2 * FRAC_BITS + 1);
   localparam int OutWidth    = lmbs_pkg::FIELD_CHANNEL_WIDTH;

   logic [3:0]                ok_bits;
   logic [CHANNEL_BITS-1:0]   chan       [3][4];
   logic                      prod_valid_ff;
   logic [ProdWidth-1:0]      prod_ff    [3][4];
   logic                      prod_ready;
   logic                      out_stage_ready;
   logic [SumWidth-1:0]       sum        [3];
   logic [ResWidth+OutWidth-1:0] res_wide [3];
   logic [2:0][OutWidth-1:0]  light_in;

   assign ok_bits = in_ok;

   // Neighbors outside the map memory read as zero.
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int n = 0; n < 4; n++) begin
            chan[ch][n] = ok_bits[n] ? word[n][ch*CHANNEL_BITS +: CHANNEL_BITS] : '0;
         end
      end
   end

   // Handshake of the two stages.
   assign out_stage_ready = !out_valid || out_ready;
   assign prod_ready      = !prod_valid_ff || out_stage_ready;
   assign in_ready        = prod_ready;

   // Product stage: twelve channel-by-weight products.
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (prod_ready) begin
         prod_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready) begin
         for (int ch = 0; ch < 3; ch++) begin
            for (int n = 0; n < 4; n++) begin
               prod_ff[ch][n] <= ProdWidth'(chan[ch][n]) * ProdWidth'(weight[n]);
            end
         end
      end
   end

   // Sum stage: the weights total 2^(2F), so dropping 2F+1 bits scales and halves.
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch] = SumWidth'(prod_ff[ch][0]) + SumWidth'(prod_ff[ch][1])
                 + SumWidth'(prod_ff[ch][2]) + SumWidth'(prod_ff[ch][3]);
         res_wide[ch] = (ResWidth + OutWidth)'(sum[ch][SumWidth-1:2*FRAC_BITS+1]);
         if (|res_wide[ch][ResWidth+OutWidth-1:OutWidth]) begin
            light_in[ch] = '1;
         end else begin
            light_in[ch] = res_wide[ch][OutWidth-1:0];
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (out_stage_ready) begin
         out_valid <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_stage_ready) begin
         light <= light_in;
      end
   end

endmodule

@@ rtl/light_map_bilinear_sampler.sv @@
// Bilinear RGB light map sampler, top level; uses lmbs_pkg, lmbs_axis,
// lmbs_light_mem and lmbs_blend.
// Throughput: one item per clock, write or query, as long as rsp_tready allows.
// A query passes the split, address, memory read, product and output registers in turn.
// The two map copies each serve two neighbors in one read cycle; writes retire there in order.
// Reset clears the pipeline and sets a 64x64 map at origin zero; map contents are not cleared.
module light_map_bilinear_sampler #(
   parameter int MAP_DEPTH    = 4096,
   parameter int FRAC_BITS    = 8,
   parameter int CHANNEL_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request stream.
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // point_x[23:0], point_y[47:24], entry_index[59:48], entry_red[75:60],
   // entry_green[91:76], entry_blue[107:92], zero[111:108]
   input  logic [lmbs_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,
   // command[0]
   input  logic                                   req_tuser,
   // Response stream.
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // light_red[15:0], light_green[31:16], light_blue[47:32]
   output logic [lmbs_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata,
   // Register write channel.
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [lmbs_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [lmbs_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   localparam int AddrWidth   = $clog2(MAP_DEPTH);
   localparam int WordWidth   = 3 * CHANNEL_BITS;
   localparam int WeightWidth = 2 * FRAC_BITS + 1;
   localparam int SizeWidth   = lmbs_pkg::SIZE_WIDTH;
   localparam int NbrWidth    = lmbs_pkg::NBR_ADDR_WIDTH;
   localparam int RowWidth    = 2 * SizeWidth;
   localparam logic [FRAC_BITS:0] FracOne = (FRAC_BITS + 1)'(1) << FRAC_BITS;
   localparam logic [NbrWidth-1:0] DepthNbr = NbrWidth'(MAP_DEPTH);
   localparam logic [31:0] DepthWord = 32'(MAP_DEPTH);
   localparam logic [WeightWidth+1:0] WeightTotal =
      (WeightWidth + 2)'(1) << (2 * FRAC_BITS);

   // Register file.
   logic [SizeWidth-1:0]                          width_ff;
   logic [SizeWidth-1:0]                          height_ff;
   logic signed [lmbs_pkg::ORIGIN_WIDTH-1:0]      origin_x_ff;
   logic signed [lmbs_pkg::ORIGIN_WIDTH-1:0]      origin_y_ff;
   logic [SizeWidth-1:0]                          width_eff;

   // Request fields.
   logic signed [lmbs_pkg::POINT_WIDTH-1:0]       req_point_x;
   logic signed [lmbs_pkg::POINT_WIDTH-1:0]       req_point_y;
   logic [lmbs_pkg::ENTRY_INDEX_WIDTH-1:0]        req_index;
   logic [WordWidth-1:0]                          req_word;

   // Split stage.
   logic [SizeWidth-1:0]                          cx_in;
   logic [SizeWidth-1:0]                          cy_in;
   logic [FRAC_BITS:0]                            fx_in;
   logic [FRAC_BITS:0]                            fy_in;
   logic                                          s1_ready;
   logic                                          s1_valid_ff;
   logic                                          s1_cmd_ff;
   logic [SizeWidth-1:0]                          s1_cx_ff;
   logic [SizeWidth-1:0]                          s1_cx_next_ff;
   logic [SizeWidth-1:0]                          s1_cy_ff;
   logic [SizeWidth-1:0]                          s1_cy_next_ff;
   logic [FRAC_BITS:0]                            s1_fx_ff;
   logic [FRAC_BITS:0]                            s1_fy_ff;
   logic [lmbs_pkg::ENTRY_INDEX_WIDTH-1:0]        s1_index_ff;
   logic                                          s1_wr_ok_ff;
   logic [WordWidth-1:0]                          s1_word_ff;

   // Address and weight stage.
   logic [FRAC_BITS:0]                            ix;
   logic [FRAC_BITS:0]                            iy;
   logic [RowWidth-1:0]                           row0;
   logic [RowWidth-1:0]                           row1;
   logic [3:0][NbrWidth-1:0]                      addr_in;
   logic [3:0][WeightWidth-1:0]                   weight_in;
   logic                                          s2_ready;
   logic                                          s2_valid_ff;
   logic                                          s2_cmd_ff;
   logic [3:0][NbrWidth-1:0]                      s2_addr_ff;
   logic [3:0][WeightWidth-1:0]                   s2_weight_ff;
   logic [lmbs_pkg::ENTRY_INDEX_WIDTH-1:0]        s2_index_ff;
   logic                                          s2_wr_ok_ff;
   logic [WordWidth-1:0]                          s2_word_ff;
   lmbs_pkg::nbr_ok_type                          ok_in;
   logic                                          mem_wr_en;

   // Memory read stage.
   logic                                          s3_ready;
   logic                                          s3_valid_ff;
   lmbs_pkg::nbr_ok_type                          s3_ok_ff;
   logic [3:0][WeightWidth-1:0]                   s3_weight_ff;
   logic [3:0][WordWidth-1:0]                     rd_word;
   logic                                          blend_ready;
   logic [2:0][lmbs_pkg::FIELD_CHANNEL_WIDTH-1:0] light;

   // Unpack the request transaction.
   assign req_point_x = req_tdata[23:0];
   assign req_point_y = req_tdata[47:24];
   assign req_index   = req_tdata[59:48];
   assign req_word    = {CHANNEL_BITS'(req_tdata[107:92]),
                         CHANNEL_BITS'(req_tdata[91:76]),
                         CHANNEL_BITS'(req_tdata[75:60])};

   // Register writes; the write channel never stalls.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= lmbs_pkg::MAP_SIZE_RESET;
         height_ff   <= lmbs_pkg::MAP_SIZE_RESET;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lmbs_pkg::CSR_MAP_WIDTH:  width_ff    <= csr_data[SizeWidth-1:0];
            lmbs_pkg::CSR_MAP_HEIGHT: height_ff   <= csr_data[SizeWidth-1:0];
            lmbs_pkg::CSR_ORIGIN_X:   origin_x_ff <= csr_data;
            lmbs_pkg::CSR_ORIGIN_Y:   origin_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign width_eff = (width_ff < lmbs_pkg::MAP_SIZE_MIN) ? lmbs_pkg::MAP_SIZE_MIN : width_ff;

   // Stage readiness: a stage loads when it is empty or its content moves on.
   assign s3_ready   = !s3_valid_ff || blend_ready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   // Split the point on both axes.
   lmbs_axis #(
      .FRAC_BITS (FRAC_BITS)
   ) u_axis_x (
      .point      (req_point_x),
      .origin     (origin_x_ff),
      .size       (width_ff),
      .cell_index (cx_in),
      .frac       (fx_in)
   );

   lmbs_axis #(
      .FRAC_BITS (FRAC_BITS)
   ) u_axis_y (
      .point      (req_point_y),
      .origin     (origin_y_ff),
      .size       (height_ff),
      .cell_index (cy_in),
      .frac       (fy_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_cmd_ff     <= req_tuser;
         s1_cx_ff      <= cx_in;
         s1_cx_next_ff <= cx_in + SizeWidth'(1);
         s1_cy_ff      <= cy_in;
         s1_cy_next_ff <= cy_in + SizeWidth'(1);
         s1_fx_ff      <= fx_in;
         s1_fy_ff      <= fy_in;
         s1_index_ff   <= req_index;
         s1_wr_ok_ff   <= 32'(req_index) < DepthWord;
         s1_word_ff    <= req_word;
      end
   end

   // Row-major neighbor addresses and the four bilinear weights.
   assign ix   = FracOne - s1_fx_ff;
   assign iy   = FracOne - s1_fy_ff;
   assign row0 = RowWidth'(s1_cy_ff) * RowWidth'(width_eff);
   assign row1 = RowWidth'(s1_cy_next_ff) * RowWidth'(width_eff);

   assign addr_in[0] = NbrWidth'(row0) + NbrWidth'(s1_cx_ff);
   assign addr_in[1] = NbrWidth'(row0) + NbrWidth'(s1_cx_next_ff);
   assign addr_in[2] = NbrWidth'(row1) + NbrWidth'(s1_cx_ff);
   assign addr_in[3] = NbrWidth'(row1) + NbrWidth'(s1_cx_next_ff);

   assign weight_in[0] = WeightWidth'(ix * iy);
   assign weight_in[1] = WeightWidth'(s1_fx_ff * iy);
   assign weight_in[2] = WeightWidth'(ix * s1_fy_ff);
   assign weight_in[3] = WeightWidth'(s1_fx_ff * s1_fy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_cmd_ff    <= s1_cmd_ff;
         s2_addr_ff   <= addr_in;
         s2_weight_ff <= weight_in;
         s2_index_ff  <= s1_index_ff;
         s2_wr_ok_ff  <= s1_wr_ok_ff;
         s2_word_ff   <= s1_word_ff;
      end
   end

   // Memory access: writes and reads are issued from the same stage in item order,
   // so a query always sees every write accepted before it.
   assign ok_in.a00 = s2_addr_ff[0] < DepthNbr;
   assign ok_in.a10 = s2_addr_ff[1] < DepthNbr;
   assign ok_in.a01 = s2_addr_ff[2] < DepthNbr;
   assign ok_in.a11 = s2_addr_ff[3] < DepthNbr;

   assign mem_wr_en = s3_ready && s2_valid_ff && (s2_cmd_ff == lmbs_pkg::CMD_WRITE)
                      && s2_wr_ok_ff;

   // Top row neighbors come from one copy, bottom row neighbors from the other.
   lmbs_light_mem #(
      .DEPTH      (MAP_DEPTH),
      .WORD_WIDTH (WordWidth)
   ) u_mem_top (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (AddrWidth'(s2_index_ff)),
      .wr_data   (s2_word_ff),
      .rd_en     (s3_ready),
      .rd_addr_a (s2_addr_ff[0][AddrWidth-1:0]),
      .rd_addr_b (s2_addr_ff[1][AddrWidth-1:0]),
      .rd_data_a (rd_word[0]),
      .rd_data_b (rd_word[1])
   );

   lmbs_light_mem #(
      .DEPTH      (MAP_DEPTH),
      .WORD_WIDTH (WordWidth)
   ) u_mem_bottom (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (AddrWidth'(s2_index_ff)),
      .wr_data   (s2_word_ff),
      .rd_en     (s3_ready),
      .rd_addr_a (s2_addr_ff[2][AddrWidth-1:0]),
      .rd_addr_b (s2_addr_ff[3][AddrWidth-1:0]),
      .rd_data_a (rd_word[2]),
      .rd_data_b (rd_word[3])
   );

   // Only queries travel past the memory stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff && (s2_cmd_ff == lmbs_pkg::CMD_QUERY);
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_ok_ff     <= ok_in;
         s3_weight_ff <= s2_weight_ff;
      end
   end

   // Weighting, halving and the response register.
   lmbs_blend #(
      .FRAC_BITS    (FRAC_BITS),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_ready  (blend_ready),
      .in_ok     (s3_ok_ff),
      .weight    (s3_weight_ff),
      .word      (rd_word),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .light     (light)
   );

   assign rsp_tdata = light;

`ifndef NO_ASSERTIONS
   // The input side only stalls when a finished result is waiting at the output.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request side stalled with no pending response");

   // The clamped x cell leaves room for its right neighbor inside the row.
   a_x_cell_in_row: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (s1_cmd_ff == lmbs_pkg::CMD_QUERY)
      |-> (s1_cx_next_ff < width_eff))
      else $error("x neighborhood leaves the map row");

   // The clamped y cell leaves room for the row below.
   a_y_cell_in_map: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (s1_cmd_ff == lmbs_pkg::CMD_QUERY)
      |-> (s1_cy_next_ff < ((height_ff < lmbs_pkg::MAP_SIZE_MIN) ?
                            lmbs_pkg::MAP_SIZE_MIN : height_ff)))
      else $error("y neighborhood leaves the map");

   // The four bilinear weights always add up to one.
   a_weights_total: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && (s2_cmd_ff == lmbs_pkg::CMD_QUERY)
      |-> ((WeightWidth + 2)'(s2_weight_ff[0]) + (WeightWidth + 2)'(s2_weight_ff[1])
           + (WeightWidth + 2)'(s2_weight_ff[2]) + (WeightWidth + 2)'(s2_weight_ff[3])
           == WeightTotal))
      else $error("bilinear weights do not sum to one");

   // A write transaction leaving the memory stage never creates a result.
   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      s3_ready && s2_valid_ff && (s2_cmd_ff == lmbs_pkg::CMD_WRITE) |=> !s3_valid_ff)
      else $error("write transaction reached the blend stage");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the bilinear light map sampler.
// It predicts every query from its own copy of the map and the registers and needs only
// lmbs_pkg and light_map_bilinear_sampler.
`timescale 1ns / 100ps

module tb_top;

   localparam int FRAC         = 8;
   localparam longint ONE      = 256;
   localparam int MAP_ENTRIES  = 4096;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;

   // One request as it travels in req_tdata, lowest field last.
   typedef struct packed {
      logic [3:0]                               pad;
      logic [lmbs_pkg::FIELD_CHANNEL_WIDTH-1:0] blue;
      logic [lmbs_pkg::FIELD_CHANNEL_WIDTH-1:0] green;
      logic [lmbs_pkg::FIELD_CHANNEL_WIDTH-1:0] red;
      logic [lmbs_pkg::ENTRY_INDEX_WIDTH-1:0]   index;
      logic [lmbs_pkg::POINT_WIDTH-1:0]         py;
      logic [lmbs_pkg::POINT_WIDTH-1:0]         px;
   } sample_req_type;

   // One light value, as a map entry and as a response.
   typedef struct packed {
      logic [15:0] blue;
      logic [15:0] green;
      logic [15:0] red;
   } light_rgb_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [lmbs_pkg::REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   logic req_tuser = lmbs_pkg::CMD_WRITE;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [lmbs_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [lmbs_pkg::CSR_INDEX_WIDTH-1:0] csr_index = lmbs_pkg::CSR_MAP_WIDTH;
   logic [lmbs_pkg::CSR_DATA_WIDTH-1:0] csr_data = '0;

   // Shadow copy of the map and the registers.
   light_rgb_type light_map [MAP_ENTRIES];
   bit map_written [MAP_ENTRIES];
   logic [lmbs_pkg::SIZE_WIDTH-1:0] map_w = lmbs_pkg::MAP_SIZE_RESET;
   logic [lmbs_pkg::SIZE_WIDTH-1:0] map_h = lmbs_pkg::MAP_SIZE_RESET;
   logic signed [lmbs_pkg::ORIGIN_WIDTH-1:0] origin_x = '0;
   logic signed [lmbs_pkg::ORIGIN_WIDTH-1:0] origin_y = '0;

   light_rgb_type pending_light [$];
   int error_count = 0;
   bit send_burst = 1'b0;
   bit recv_burst = 1'b0;
   bit hold_rsp = 1'b0;

   light_map_bilinear_sampler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= 40) begin
         $display("ERROR @%0t: %s", $time, msg);
      end
   endtask

   // Sizes below two behave as two.
   function automatic longint map_span(input logic [lmbs_pkg::SIZE_WIDTH-1:0] s);
      return (s < 2) ? 2 : longint'(s);
   endfunction

   // Split one relative coordinate into a clamped cell and a weight in [0, ONE].
   function automatic void split_axis(input longint rel,
                                      input logic [lmbs_pkg::SIZE_WIDTH-1:0] size,
                                      output longint cell_idx, output longint frac);
      longint sz;
      sz = map_span(size);
      cell_idx = rel >>> FRAC;
      frac = rel & (ONE - 1);
      if (cell_idx < 0) begin
         cell_idx = 0;
         frac = 0;
      end else if (cell_idx >= sz - 1) begin
         cell_idx = sz - 2;
         frac = ONE;
      end
   endfunction

   // Address of the upper-left neighbor and the two weights of a query point.
   function automatic void locate(input logic [lmbs_pkg::POINT_WIDTH-1:0] px, py,
                                  output longint base, output longint fx, output longint fy);
      longint cx, cy;
      split_axis(longint'($signed(px)) - longint'(origin_x) * ONE, map_w, cx, fx);
      split_axis(longint'($signed(py)) - longint'(origin_y) * ONE, map_h, cy, fy);
      base = cy * map_span(map_w) + cx;
   endfunction

   function automatic logic [15:0] blend(input logic [15:0] c00, c10, c01, c11,
                                         input longint fx, fy);
      longint ix, iy, acc;
      ix = ONE - fx;
      iy = ONE - fy;
      acc = longint'(c00) * ix * iy + longint'(c10) * fx * iy
          + longint'(c01) * ix * fy + longint'(c11) * fx * fy;
      acc = acc >> (2 * FRAC + 1);
      return (acc > 65535) ? 16'hFFFF : acc[15:0];
   endfunction

   // Halved bilinear light at a query point; neighbors past the memory read as zero.
   function automatic light_rgb_type sample_light(input logic [lmbs_pkg::POINT_WIDTH-1:0] px,
                                                  py);
      longint base, fx, fy, addr;
      light_rgb_type nbr [4];
      light_rgb_type res;
      locate(px, py, base, fx, fy);
      for (int k = 0; k < 4; k++) begin
         addr = base + (k % 2) + (k / 2) * map_span(map_w);
         nbr[k] = (addr < MAP_ENTRIES) ? light_map[addr] : '0;
      end
      res.red   = blend(nbr[0].red, nbr[1].red, nbr[2].red, nbr[3].red, fx, fy);
      res.green = blend(nbr[0].green, nbr[1].green, nbr[2].green, nbr[3].green, fx, fy);
      res.blue  = blend(nbr[0].blue, nbr[1].blue, nbr[2].blue, nbr[3].blue, fx, fy);
      return res;
   endfunction

   // Offer one request, wait for its transaction, then update the shadow state.
   task automatic send_item(input logic cmd, input sample_req_type item);
      int gap;
      logic taken;
      gap = send_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= item;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      if (cmd == lmbs_pkg::CMD_WRITE) begin
         light_map[item.index]   = {item.blue, item.green, item.red};
         map_written[item.index] = 1'b1;
      end else begin
         pending_light.push_back(sample_light(item.px, item.py));
      end
   endtask

   task automatic write_entry(input logic [11:0] idx, input logic [15:0] r, g, b);
      sample_req_type item;
      item = {4'h0, b, g, r, idx, 24'($urandom), 24'($urandom)};
      send_item(lmbs_pkg::CMD_WRITE, item);
   endtask

   // A query first loads any neighbor inside the memory that was never written.
   task automatic query_point(input logic [lmbs_pkg::POINT_WIDTH-1:0] px, py);
      longint base, fx, fy, addr;
      sample_req_type item;
      locate(px, py, base, fx, fy);
      for (int k = 0; k < 4; k++) begin
         addr = base + (k % 2) + (k / 2) * map_span(map_w);
         if (addr < MAP_ENTRIES && !map_written[addr]) begin
            write_entry(addr[11:0], 16'($urandom), 16'($urandom), 16'($urandom));
         end
      end
      item = {4'h0, 16'($urandom), 16'($urandom), 16'($urandom), 12'($urandom), py, px};
      send_item(lmbs_pkg::CMD_QUERY, item);
   endtask

   // Stop sending and let every outstanding result and write retire.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_light.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [lmbs_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [lmbs_pkg::CSR_DATA_WIDTH-1:0] value);
      logic taken;
      wait_for_drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      case (idx)
         lmbs_pkg::CSR_MAP_WIDTH:  map_w = value[lmbs_pkg::SIZE_WIDTH-1:0];
         lmbs_pkg::CSR_MAP_HEIGHT: map_h = value[lmbs_pkg::SIZE_WIDTH-1:0];
         lmbs_pkg::CSR_ORIGIN_X:   origin_x = value;
         lmbs_pkg::CSR_ORIGIN_Y:   origin_y = value;
         default: ;
      endcase
   endtask

   task automatic set_map(input logic [15:0] w, h, ox, oy);
      csr_write(lmbs_pkg::CSR_MAP_WIDTH, w);
      csr_write(lmbs_pkg::CSR_MAP_HEIGHT, h);
      csr_write(lmbs_pkg::CSR_ORIGIN_X, ox);
      csr_write(lmbs_pkg::CSR_ORIGIN_Y, oy);
   endtask

   // Mostly small maps, sometimes large ones or sizes outside the usual range.
   function automatic logic [15:0] rand_size();
      case ($urandom_range(0, 19))
         0:       return 16'($urandom_range(0, 8191));
         1, 2:    return 16'($urandom_range(2, 4096));
         3, 4, 5: return 16'($urandom_range(2, 96));
         default: return 16'($urandom_range(2, 12));
      endcase
   endfunction

   function automatic logic [15:0] rand_origin();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 16'(int'($urandom_range(0, 128)) - 64);
         5, 6, 7:       return 16'($urandom);
         default:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      endcase
   endfunction

   // A coordinate mostly around the map, sometimes on its edges, sometimes anywhere.
   function automatic logic [lmbs_pkg::POINT_WIDTH-1:0] rand_coord(
      input logic [lmbs_pkg::SIZE_WIDTH-1:0] size,
      input logic signed [15:0] org,
      input longint span);
      longint sz, cell_pos, frac, v;
      int mode;
      sz = map_span(size);
      mode = $urandom_range(0, 9);
      frac = $urandom_range(0, 255);
      if (mode < 2) begin
         v = $urandom;
         return v[lmbs_pkg::POINT_WIDTH-1:0];
      end
      if (mode == 2) begin
         case ($urandom_range(0, 3))
            0:       cell_pos = 0;
            1:       cell_pos = sz - 2;
            2:       cell_pos = sz - 1;
            default: cell_pos = sz;
         endcase
         frac = $urandom_range(0, 1) ? 0 : 255;
      end else begin
         cell_pos = longint'($urandom_range(0, 32'(span + 2))) - 2;
      end
      v = longint'(org) * ONE + cell_pos * ONE + frac;
      return v[lmbs_pkg::POINT_WIDTH-1:0];
   endfunction

   // Random write or query; query rows stay mostly where entries fit in the memory.
   task automatic random_item();
      longint row_span;
      row_span = MAP_ENTRIES / map_span(map_w) + 1;
      if (row_span > map_span(map_h) + 1) row_span = map_span(map_h) + 1;
      if ($urandom_range(0, 4) == 0) begin
         write_entry(12'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
         query_point(rand_coord(map_w, origin_x, map_span(map_w) + 1),
                     rand_coord(map_h, origin_y, row_span));
      end
   endtask

   // Directed corners of the default 64 by 64 map at origin zero.
   task automatic test_default_map();
      write_entry(12'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      write_entry(12'd4095, 16'h0000, 16'h0000, 16'h0000);
      write_entry(12'd65, 16'h8000, 16'h1234, 16'hFFFF);
      query_point(24'h000000, 24'h000000);
      query_point(24'h7FFFFF, 24'h800000);
      query_point(24'h003F00, 24'h003F00);
      query_point(24'h003EFF, 24'h003E80);
      query_point(24'hFFFFFF, 24'hFFFFFF);
      query_point(24'h800000, 24'h7FFFFF);
      query_point(24'h000080, 24'h000080);
   endtask

   // Degenerate sizes, the largest maps, extreme origins and neighbors past the memory.
   task automatic test_map_limits();
      set_map(16'd1, 16'd0, 16'd0, 16'd0);
      query_point(24'h000080, 24'h000040);
      query_point(24'h7FFFFF, 24'h7FFFFF);
      set_map(16'd4096, 16'd4096, 16'h8000, 16'h7FFF);
      query_point(24'h7FFFFF, 24'h800000);
      query_point(24'h80054D, 24'h7FFFFF);
      set_map(16'd4096, 16'd4096, 16'h8000, 16'h8000);
      query_point(24'h800000, 24'h800000);
      query_point(24'h80034D, 24'h8FFE00);
      set_map(16'd8191, 16'd3, 16'h7FFF, 16'h0000);
      query_point(24'h7FFF80, 24'h000180);
   endtask

   // Several register settings with a stretch of random traffic each.
   task automatic test_random_maps();
      for (int p = 0; p < 8; p++) begin
         case (p)
            0:       set_map(16'd2, 16'd2, 16'd0, 16'd0);
            1:       set_map(16'd4096, 16'd4096, 16'h8000, 16'h7FFF);
            7:       set_map(16'd64, 16'd64, 16'd0, 16'd0);
            default: set_map(rand_size(), rand_size(), rand_origin(), rand_origin());
         endcase
         for (int i = 0; i < 190; i++) begin
            if (i % 50 == 0) send_burst = ($urandom_range(0, 3) == 0);
            random_item();
         end
      end
      send_burst = 1'b0;
   endtask

   // The sink holds off for a long time while requests keep coming back to back.
   task automatic test_backpressure();
      set_map(16'd16, 16'd12, 16'hFFFE, 16'd3);
      hold_rsp = 1'b1;
      send_burst = 1'b1;
      repeat (80) random_item();
      send_burst = 1'b0;
   endtask

   // The source stops until every result is back, then resumes.
   task automatic test_drain_pause();
      repeat (3) begin
         repeat (20) random_item();
         wait_for_drain();
      end
   endtask

   // Response sink: random stalls, bursts without stalls, and the long hold-off.
   initial begin : rsp_sink
      int stall;
      int n;
      logic fired;
      n = 0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         if (n % 40 == 0) recv_burst = ($urandom_range(0, 3) == 0);
         stall = recv_burst ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do begin
            @(negedge clock);
            fired = rsp_tvalid;
            @(posedge clock);
         end while (!fired);
         n++;
      end
   end

   // Compare each response transaction with the oldest predicted light value.
   initial begin : light_checker
      light_rgb_type got;
      light_rgb_type want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_light.size() == 0) begin
               report_error($sformatf("unexpected response %h", got));
            end else begin
               want = pending_light.pop_front();
               if (got.red !== want.red)
                  report_error($sformatf("red %h, predicted %h", got.red, want.red));
               if (got.green !== want.green)
                  report_error($sformatf("green %h, predicted %h", got.green, want.green));
               if (got.blue !== want.blue)
                  report_error($sformatf("blue %h, predicted %h", got.blue, want.blue));
            end
         end
      end
   end

   initial begin : run
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_default_map();
      test_map_limits();
      test_random_maps();
      test_backpressure();
      test_drain_pause();
      wait_for_drain();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
